[hw/rtl/hcbe_pkg.sv]
// ----------------------------------------------------------------------------
// hcbe_pkg: shared definitions for the chunked body extractor
// Field widths, character codes, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbe_pkg;

	// Default width of the chunk size accumulator and the remaining-byte counter.
	localparam int LengthBitsDefault = 32;

	// Fixed payload widths.
	localparam int ByteW   = 8;
	localparam int BodyLenW = 32;
	localparam int StatusW = 2;

	typedef logic [ByteW-1:0]    byte_t;
	typedef logic [BodyLenW-1:0] body_len_t;
	typedef logic [StatusW-1:0]  status_t;

	// Character codes.
	localparam byte_t CH_CR = 8'd13;
	localparam byte_t CH_LF = 8'd10;

	// Status codes reported with the final beat of a response.
	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_NO_HDR_END = 2'd1;
	localparam status_t ST_OVERFLOW   = 2'd2;
	localparam status_t ST_TRUNCATED  = 2'd3;

	// Hex digit value; any character that is not a hex digit counts as zero.
	function automatic logic [3:0] hex_value(input byte_t c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			v = 4'(c - 8'd48);
		end else if (c >= 8'd97 && c <= 8'd102) begin
			v = 4'(c - 8'd87);
		end else if (c >= 8'd65 && c <= 8'd70) begin
			v = 4'(c - 8'd55);
		end
		return v;
	endfunction

endpackage

[hw/rtl/hcbe_if.sv]
// ----------------------------------------------------------------------------
// hcbe_if: stream interfaces of the chunked body extractor
// Response byte channel in and extracted body channel out, valid/ready.
// ----------------------------------------------------------------------------
interface hcbe_in_if;
	import hcbe_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface hcbe_out_if;
	import hcbe_pkg::*;

	logic      valid;
	logic      ready;
	byte_t     body_byte;
	logic      body_valid;
	logic      done_res;
	body_len_t body_length;
	status_t   status;

	modport source (output valid, output body_byte, output body_valid, output done_res,
		output body_length, output status, input ready);
	modport sink   (input valid, input body_byte, input body_valid, input done_res,
		input body_length, input status, output ready);
endinterface

[hw/rtl/http_chunked_body_extractor.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_extractor: HTTP response body extractor
// Strips the header of an HTTP response and passes the body, optionally
// decoding chunked transfer encoding, with a length and status at the end.
// ----------------------------------------------------------------------------
// Usage:
// Response bytes arrive on byte_in, one per beat, with last on the final
// byte of a response. Body bytes leave on body_out; the final byte of a
// response always gives a beat (done_res set) carrying the body length and
// status, even if it is not a body byte itself. Bytes that are neither body
// nor final give no output beat.
// cfg_wr_en/cfg_wr_data set chunked mode; it is sampled when the header end
// is found, so write it while the block is idle.
// Throughput is one byte per cycle while body_out.ready stays high. An accepted
// byte reaches its output beat through the input register, then the parse logic
// feeding the output register.
// Reset clears all parse state and selects pass-through mode. After each
// final byte the parse state returns to its reset value, the mode is kept.
// When the receiver stalls, the output register holds its beat; the next byte
// that gives a beat is parked in the input register, then byte_in.ready drops.
// ----------------------------------------------------------------------------
module http_chunked_body_extractor #(
	parameter int LENGTH_BITS = hcbe_pkg::LengthBitsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	hcbe_in_if.sink         byte_in,
	hcbe_out_if.source      body_out,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data
);
	import hcbe_pkg::*;

	localparam int LB = LENGTH_BITS;

	// Parse phases.
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_RAW    = 3'd1;
	localparam logic [2:0] PH_SIZE   = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;

	// One hex digit shifted into the size accumulator, saturating on overflow.
	// The top bit of the result flags the overflow.
	function automatic logic [LB:0] push_digit(input logic [LB-1:0] acc,
		input logic [3:0] d);
		logic [LB:0] r;
		if (acc[LB-1 -: 4] != 4'd0) begin
			r = {1'b1, {LB{1'b1}}};
		end else begin
			r = {1'b0, acc[LB-5:0], d};
		end
		return r;
	endfunction

	// Configuration register.
	logic chunked_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			chunked_mode_q <= cfg_wr_data;
		end
	end

	// Input register stage.
	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;
	logic  res_s1;
	logic  move_s1;
	logic  out_valid_q;

	assign move_s1 = valid_s1 && (!res_s1 || !out_valid_q || body_out.ready);
	assign byte_in.ready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last;
		end
	end

	// Parse state.
	logic [2:0]    phase_q;
	logic [1:0]    hdr_match_q;
	logic [LB-1:0] size_acc_q;
	logic          pending_cr_q;
	logic [LB-1:0] remaining_q;
	logic [1:0]    skip_cnt_q;
	body_len_t     length_q;
	logic [1:0]    err_q;

	logic [2:0]    phase_d;
	logic [1:0]    hdr_match_d;
	logic [LB-1:0] size_acc_d;
	logic          pending_cr_d;
	logic [LB-1:0] remaining_d;
	logic [1:0]    skip_cnt_d;
	body_len_t     length_d;
	logic [1:0]    err_d;
	logic          emit;
	status_t       status_d;
	logic [LB:0]   push_a;
	logic [LB:0]   push_b;
	logic [LB-1:0] rem_dec;

	// Next state and result for the byte in the input register.
	always_comb begin
		phase_d      = phase_q;
		hdr_match_d  = hdr_match_q;
		size_acc_d   = size_acc_q;
		pending_cr_d = pending_cr_q;
		remaining_d  = remaining_q;
		skip_cnt_d   = skip_cnt_q;
		err_d        = err_q;
		emit         = 1'b0;
		status_d     = ST_OK;
		rem_dec      = remaining_q - 1'b1;
		// A lone CR counts as a zero digit before the current byte is taken.
		push_a = pending_cr_q ? push_digit(size_acc_q, 4'd0) : {1'b0, size_acc_q};
		push_b = push_digit(push_a[LB-1:0], hex_value(data_s1));

		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_match_q == 2'd3 && data_s1 == CH_LF) begin
					hdr_match_d = 2'd0;
					if (chunked_mode_q) begin
						phase_d      = PH_SIZE;
						size_acc_d   = '0;
						pending_cr_d = 1'b0;
					end else begin
						phase_d = PH_RAW;
					end
				end else if (hdr_match_q[0] && data_s1 == CH_LF) begin
					hdr_match_d = 2'd2;
				end else if (data_s1 == CH_CR) begin
					hdr_match_d = (hdr_match_q == 2'd2) ? 2'd3 : 2'd1;
				end else begin
					hdr_match_d = 2'd0;
				end
			end
			PH_RAW: begin
				emit = 1'b1;
			end
			PH_SIZE: begin
				if (pending_cr_q && data_s1 == CH_LF) begin
					pending_cr_d = 1'b0;
					if (size_acc_q == '0) begin
						phase_d    = PH_SKIP;
						skip_cnt_d = 2'd2;
					end else begin
						phase_d     = PH_DATA;
						remaining_d = size_acc_q;
					end
					size_acc_d = '0;
				end else if (data_s1 == CH_CR) begin
					pending_cr_d = 1'b1;
					size_acc_d   = push_a[LB-1:0];
					err_d[0]     = err_q[0] | push_a[LB];
				end else begin
					pending_cr_d = 1'b0;
					size_acc_d   = push_b[LB-1:0];
					err_d[0]     = err_q[0] | push_a[LB] | push_b[LB];
				end
			end
			PH_DATA: begin
				emit        = 1'b1;
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d    = PH_SKIP;
					skip_cnt_d = 2'd2;
				end
			end
			default: begin
				skip_cnt_d = skip_cnt_q - 2'd1;
				if (skip_cnt_d == 2'd0) begin
					phase_d      = PH_SIZE;
					size_acc_d   = '0;
					pending_cr_d = 1'b0;
				end
			end
		endcase

		// Saturating body length.
		length_d = length_q;
		if (emit && length_q != '1) begin
			length_d = length_q + 1'b1;
		end

		// Final status: missing header end, then overflow, then truncation.
		if (last_s1) begin
			if (phase_d == PH_DATA && remaining_d != '0) begin
				err_d[1] = 1'b1;
			end
			if (phase_d == PH_HEADER) begin
				status_d = ST_NO_HDR_END;
			end else if (err_d[0]) begin
				status_d = ST_OVERFLOW;
			end else if (err_d[1]) begin
				status_d = ST_TRUNCATED;
			end
		end
	end

	assign res_s1 = emit || last_s1;

	// State update; the final byte returns the parse state to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_match_q  <= 2'd0;
			size_acc_q   <= '0;
			pending_cr_q <= 1'b0;
			remaining_q  <= '0;
			skip_cnt_q   <= 2'd0;
			length_q     <= '0;
			err_q        <= 2'd0;
		end else if (move_s1) begin
			if (last_s1) begin
				phase_q      <= PH_HEADER;
				hdr_match_q  <= 2'd0;
				size_acc_q   <= '0;
				pending_cr_q <= 1'b0;
				remaining_q  <= '0;
				skip_cnt_q   <= 2'd0;
				length_q     <= '0;
				err_q        <= 2'd0;
			end else begin
				phase_q      <= phase_d;
				hdr_match_q  <= hdr_match_d;
				size_acc_q   <= size_acc_d;
				pending_cr_q <= pending_cr_d;
				remaining_q  <= remaining_d;
				skip_cnt_q   <= skip_cnt_d;
				length_q     <= length_d;
				err_q        <= err_d;
			end
		end
	end

	// Output register.
	byte_t     body_byte_q;
	logic      body_valid_q;
	logic      done_q;
	body_len_t body_len_q;
	status_t   status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (body_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && res_s1) begin
			body_byte_q  <= emit ? data_s1 : 8'd0;
			body_valid_q <= emit;
			done_q       <= last_s1;
			body_len_q   <= length_d;
			status_q     <= status_d;
		end
	end

	assign body_out.valid       = out_valid_q;
	assign body_out.body_byte   = body_byte_q;
	assign body_out.body_valid  = body_valid_q;
	assign body_out.done_res    = done_q;
	assign body_out.body_length = body_len_q;
	assign body_out.status      = status_q;

endmodule

[hw/rtl/hcbe_checker.sv]
// ----------------------------------------------------------------------------
// hcbe_checker: port-level checks for the chunked body extractor
// Watches the body output channel and flags inconsistent beats.
// ----------------------------------------------------------------------------
module hcbe_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_ready,
	input  hcbe_pkg::byte_t     body_byte,
	input  logic                body_valid,
	input  logic                done_res,
	input  hcbe_pkg::body_len_t body_length,
	input  hcbe_pkg::status_t   status
);
	import hcbe_pkg::*;

	// A stalled beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(body_byte)
			&& $stable(body_valid) && $stable(done_res) && $stable(body_length)
			&& $stable(status))
		else $error("output beat changed while stalled");

	// Every beat carries a body byte or ends a response.
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> body_valid || done_res)
		else $error("output beat with neither body byte nor end");

	// Status is only reported on the final beat.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == ST_OK)
		else $error("status set on a beat that is not final");

	// A response whose header never ended has no body.
	a_nohdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res && status == ST_NO_HDR_END
			|-> body_length == '0 && !body_valid && body_byte == '0)
		else $error("body reported without a header end");

endmodule

bind http_chunked_body_extractor hcbe_checker u_hcbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (body_out.valid),
	.out_ready   (body_out.ready),
	.body_byte   (body_out.body_byte),
	.body_valid  (body_out.body_valid),
	.done_res    (body_out.done_res),
	.body_length (body_out.body_length),
	.status      (body_out.status)
);

[dv/tb_http_chunked_body_extractor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_extractor: self-checking bench for the body extractor
// Drives HTTP responses byte by byte in pass-through and chunked mode,
// predicts every output beat from a behavioral parser and checks each beat
// field by field. Directed responses cover the edge cases; random responses
// mix well-formed chunked bodies with truncated, oversized and noisy input.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_extractor;
	import hcbe_pkg::*;

	localparam int TimeoutNs    = 3_000_000;
	localparam int SettleCycles = 6;
	localparam int DrainLimit   = 20_000;
	localparam int HoldCycles   = 80;
	localparam int TargetItems  = 700;

	// Error flag bits of the parser.
	localparam int FlagOverflow  = 0;
	localparam int FlagTruncated = 1;

	typedef enum logic [2:0] {
		PARSE_HEADER,
		PARSE_RAW,
		PARSE_SIZE,
		PARSE_DATA,
		PARSE_SKIP
	} parse_phase_t;

	typedef struct packed {
		byte_t     body_byte;
		logic      body_valid;
		logic      done_res;
		body_len_t body_length;
		status_t   status;
	} body_beat_t;

	// Behavioral body parser plus the queue of body beats it predicts.
	class body_scoreboard;
		logic         chunked_mode;
		parse_phase_t parse_st;
		logic [1:0]   crlf_seen;
		logic [31:0]  size_acc;
		logic         cr_pending;
		logic [31:0]  owed;
		logic [1:0]   skip_left;
		body_len_t    length_total;
		logic [1:0]   err_flags;
		body_beat_t   expected_beats[$];
		int           errors;
		int           beats_checked;
		int           body_items;
		int           items_in;
		int           responses;
		int           status_seen[4];

		function new();
			chunked_mode = 1'b0;
			clear_stream();
			errors = 0;
			beats_checked = 0;
			body_items = 0;
			items_in = 0;
			responses = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void clear_stream();
			parse_st = PARSE_HEADER;
			crlf_seen = '0;
			size_acc = '0;
			cr_pending = 1'b0;
			owed = '0;
			skip_left = '0;
			length_total = '0;
			err_flags = '0;
		endfunction

		// Hex digit weight; anything else weighs nothing.
		function logic [3:0] digit_of(byte_t c);
			if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
			if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
			if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
			return 4'd0;
		endfunction

		// Append one digit to the chunk size, saturating on overflow.
		function void shift_digit(logic [3:0] d);
			logic [63:0] ceiling;
			ceiling = (64'hFFFF_FFFF - 64'(d)) >> 4;
			if (64'(size_acc) > ceiling) begin
				size_acc = '1;
				err_flags[FlagOverflow] = 1'b1;
			end else begin
				size_acc = {size_acc[27:0], d};
			end
		endfunction

		// Advance the parser by one accepted byte and queue its beat, if any.
		function void note_byte(byte_t b, logic lst);
			logic       emit;
			status_t    st;
			body_beat_t beat;
			emit = 1'b0;
			st = ST_OK;
			items_in++;
			if (parse_st != PARSE_HEADER) body_items++;
			case (parse_st)
				PARSE_HEADER: begin
					if (crlf_seen == 2'd3 && b == CH_LF) begin
						crlf_seen = '0;
						if (chunked_mode) begin
							parse_st = PARSE_SIZE;
							size_acc = '0;
							cr_pending = 1'b0;
						end else begin
							parse_st = PARSE_RAW;
						end
					end else if (crlf_seen[0] && b == CH_LF) begin
						crlf_seen = 2'd2;
					end else if (b == CH_CR) begin
						crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
					end else begin
						crlf_seen = '0;
					end
				end
				PARSE_RAW: emit = 1'b1;
				PARSE_SIZE: begin
					if (cr_pending && b == CH_LF) begin
						cr_pending = 1'b0;
						if (size_acc == 0) begin
							parse_st = PARSE_SKIP;
							skip_left = 2'd2;
						end else begin
							parse_st = PARSE_DATA;
							owed = size_acc;
						end
						size_acc = '0;
					end else begin
						// A CR that is not followed by LF weighs as a zero digit.
						if (cr_pending) shift_digit(4'd0);
						if (b == CH_CR) begin
							cr_pending = 1'b1;
						end else begin
							cr_pending = 1'b0;
							shift_digit(digit_of(b));
						end
					end
				end
				PARSE_DATA: begin
					emit = 1'b1;
					owed = owed - 32'd1;
					if (owed == 0) begin
						parse_st = PARSE_SKIP;
						skip_left = 2'd2;
					end
				end
				default: begin
					skip_left = skip_left - 2'd1;
					if (skip_left == 0) begin
						parse_st = PARSE_SIZE;
						size_acc = '0;
						cr_pending = 1'b0;
					end
				end
			endcase

			if (emit && length_total != '1) length_total++;

			if (lst) begin
				if (parse_st == PARSE_DATA && owed != 0) err_flags[FlagTruncated] = 1'b1;
				if (parse_st == PARSE_HEADER) st = ST_NO_HDR_END;
				else if (err_flags[FlagOverflow]) st = ST_OVERFLOW;
				else if (err_flags[FlagTruncated]) st = ST_TRUNCATED;
			end

			if (emit || lst) begin
				beat.body_byte = emit ? b : '0;
				beat.body_valid = emit;
				beat.done_res = lst;
				beat.body_length = length_total;
				beat.status = st;
				expected_beats.push_back(beat);
			end

			if (lst) begin
				responses++;
				clear_stream();
			end
		endfunction

		// Compare one output beat with the oldest prediction.
		function void check_beat(body_beat_t got);
			body_beat_t want;
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: body_byte %0d, done_res %0b with nothing outstanding",
					got.body_byte, got.done_res);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			if (got.body_byte !== want.body_byte) begin
				$error("body_byte: expected %0d, actual %0d", want.body_byte, got.body_byte);
				errors++;
			end
			if (got.body_valid !== want.body_valid) begin
				$error("body_valid: expected %0b, actual %0b", want.body_valid, got.body_valid);
				errors++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res: expected %0b, actual %0b", want.done_res, got.done_res);
				errors++;
			end
			if (got.body_length !== want.body_length) begin
				$error("body_length: expected %0d, actual %0d", want.body_length,
					got.body_length);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			beats_checked++;
			if (want.done_res) status_seen[want.status]++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	hcbe_in_if  byte_in_if ();
	hcbe_out_if body_out_if ();

	body_scoreboard sb = new();

	int burst_left;
	int hold_requests;

	http_chunked_body_extractor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in_if),
		.body_out   (body_out_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#(TimeoutNs);
		$display("TB_ERROR");
		$finish;
	end

	// Monitors: predict on every accepted byte, check every accepted beat.
	always @(posedge clk) begin
		body_beat_t got;
		if (arst_n && byte_in_if.valid && byte_in_if.ready) begin
			sb.note_byte(byte_in_if.data_byte, byte_in_if.last);
		end
		if (arst_n && body_out_if.valid && body_out_if.ready) begin
			got.body_byte = body_out_if.body_byte;
			got.body_valid = body_out_if.body_valid;
			got.done_res = body_out_if.done_res;
			got.body_length = body_out_if.body_length;
			got.status = body_out_if.status;
			sb.check_beat(got);
		end
	end

	// Receiver: rotating stall pattern, re-drawn now and then, plus long holds on request.
	initial begin
		logic [15:0] stall_pat;
		int pat_age;
		int hold_left;
		int holds_served;
		body_out_if.ready = 1'b0;
		stall_pat = '1;
		pat_age = 0;
		hold_left = 0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_served < hold_requests) begin
				holds_served++;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				body_out_if.ready = 1'b0;
				hold_left--;
			end else begin
				if (pat_age == 0) begin
					pat_age = $urandom_range(32, 96);
					case ($urandom_range(0, 2))
						0: stall_pat = '1;
						1: stall_pat = 16'($urandom) | 16'h0101;
						default: stall_pat = 16'($urandom) & 16'($urandom) | 16'h8000;
					endcase
				end
				pat_age--;
				body_out_if.ready = stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[15:1]};
			end
		end
	end

	// Offer one byte and wait for it to be taken; the sender works in bursts.
	task automatic send_byte(byte_t b, logic lst);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				byte_in_if.valid = 1'b0;
				byte_in_if.data_byte = 8'($urandom);
				byte_in_if.last = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		byte_in_if.valid = 1'b1;
		byte_in_if.data_byte = b;
		byte_in_if.last = lst;
		do @(posedge clk); while (!byte_in_if.ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_response(byte_t q[$]);
		foreach (q[i]) send_byte(q[i], i == q.size() - 1);
	endtask

	// Stop sending until every predicted beat is out (or the drain limit is reached) and the pipeline has settled.
	task automatic wait_idle();
		int waited;
		byte_in_if.valid = 1'b0;
		byte_in_if.last = 1'b0;
		waited = 0;
		while (sb.expected_beats.size() != 0 && waited < DrainLimit) begin
			@(negedge clk);
			waited++;
		end
		repeat (SettleCycles) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_mode(logic m);
		cfg_wr_en = 1'b1;
		cfg_wr_data = m;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.chunked_mode = m;
	endtask

	function automatic void add_text(ref byte_t q[$], input string s);
		foreach (s[i]) q.push_back(byte_t'(s[i]));
	endfunction

	function automatic void add_random(ref byte_t q[$], input int n);
		repeat (n) q.push_back(byte_t'($urandom));
	endfunction

	// Header of a few random lines, closed by an empty line.
	function automatic void add_header(ref byte_t q[$]);
		int lines;
		lines = $urandom_range(1, 3);
		repeat (lines) begin
			repeat ($urandom_range(0, 10)) begin
				case ($urandom_range(0, 19))
					0: q.push_back(CH_CR);
					1: q.push_back(byte_t'($urandom));
					default: q.push_back(byte_t'($urandom_range(32, 126)));
				endcase
			end
			add_text(q, "\r\n");
		end
		add_text(q, "\r\n");
	endfunction

	// One chunk: size line in varied spelling, the data, and the two trailing bytes.
	function automatic void add_chunk(ref byte_t q[$], input int unsigned n);
		string digits;
		string junk;
		junk = " xg;zG";
		digits = $sformatf("%0h", n);
		if ($urandom_range(0, 1)) digits = digits.toupper();
		case ($urandom_range(0, 9))
			0: digits = {"0", digits};
			1: q.push_back(byte_t'(junk[$urandom_range(0, junk.len() - 1)]));
			2: q.push_back(CH_CR);
			default: ;
		endcase
		add_text(q, {digits, "\r\n"});
		add_random(q, n);
		if ($urandom_range(0, 9) == 0) add_random(q, 2);
		else add_text(q, "\r\n");
	endfunction

	function automatic void add_chunked_body(ref byte_t q[$]);
		repeat ($urandom_range(1, 4)) begin
			add_chunk(q, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24));
		end
		// An oversized or maximal size line ends the response inside its data.
		if ($urandom_range(0, 14) == 0) begin
			if ($urandom_range(0, 1)) add_text(q, {"1", $sformatf("%08h", $urandom), "\r\n"});
			else add_text(q, "FFFFFFFF\r\n");
			add_random(q, $urandom_range(1, 6));
			return;
		end
		add_chunk(q, 0);
		if ($urandom_range(0, 5) == 0) add_chunk(q, $urandom_range(1, 8));
	endfunction

	function automatic void build_random_response(ref byte_t q[$], input logic chunked);
		int pick;
		q.delete();
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			repeat ($urandom_range(1, 16)) begin
				case ($urandom_range(0, 5))
					0: q.push_back(CH_CR);
					1: q.push_back(CH_LF);
					default: q.push_back(byte_t'($urandom));
				endcase
			end
			return;
		end
		add_header(q);
		if (chunked ? (pick < 5) : (pick >= 7)) add_random(q, $urandom_range(0, 30));
		else add_chunked_body(q);
		if ($urandom_range(0, 4) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
	endfunction

	// Stimulus.
	initial begin
		byte_t resp[$];
		logic mode;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		byte_in_if.valid = 1'b0;
		byte_in_if.data_byte = '0;
		byte_in_if.last = 1'b0;
		burst_left = 0;
		hold_requests = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Pass-through: extreme body bytes, then a response with no header end.
		write_mode(1'b0);
		resp = {};
		add_text(resp, "\r\n\r\n");
		resp.push_back(8'h00);
		resp.push_back(8'hFF);
		send_response(resp);
		resp = {8'h41};
		send_response(resp);
		wait_idle();

		// Chunked: lone CR in a size line, then a size line that saturates.
		write_mode(1'b1);
		resp = {};
		add_text(resp, "\r\n\r\n\r1\r\n");
		resp.push_back(8'hFF);
		add_text(resp, "\r\nfffffffff\r\n");
		send_response(resp);
		wait_idle();

		// Back-pressure: the receiver holds off while a long raw body is offered.
		write_mode(1'b0);
		hold_requests++;
		resp = {};
		add_header(resp);
		add_random(resp, 40);
		send_response(resp);
		wait_idle();

		// Random phases, each under its own mode setting.
		mode = 1'b1;
		while (sb.items_in < TargetItems) begin
			write_mode(mode);
			repeat ($urandom_range(4, 10)) begin
				if (sb.items_in >= TargetItems) break;
				build_random_response(resp, mode);
				send_response(resp);
			end
			wait_idle();
			mode = ($urandom_range(0, 3) != 0);
		end

		wait_idle();
		if (sb.expected_beats.size() != 0) begin
			$error("%0d expected beats never arrived", sb.expected_beats.size());
			sb.errors++;
		end
		$display("Run covered %0d responses, %0d bytes (%0d past the header), %0d beats checked.",
			sb.responses, sb.items_in, sb.body_items, sb.beats_checked);
		$display("Final status seen: ok %0d, no header end %0d, overflow %0d, truncated %0d.",
			sb.status_seen[ST_OK], sb.status_seen[ST_NO_HDR_END],
			sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_TRUNCATED]);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/hcbe_pkg.sv
hw/rtl/hcbe_if.sv
hw/rtl/http_chunked_body_extractor.sv
hw/rtl/hcbe_checker.sv
dv/tb_http_chunked_body_extractor.sv
